// ===== design/cbs_pkg.sv =====
// ----------------------------------------------------------------------------
// cbs_pkg: shared types and constants of the CIGAR block splitter
// Operation codes, register indexes, request and result structs, saturating add.
// ----------------------------------------------------------------------------
package cbs_pkg;

  localparam int unsigned POS_W = 32;
  localparam int unsigned LEN_W = 28;
  localparam int unsigned CODE_W = 4;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 1;

  localparam logic [POS_W-1:0] POS_MAX = '1;

  typedef enum logic [CODE_W-1:0] {
    OP_M  = 4'd0,
    OP_I  = 4'd1,
    OP_D  = 4'd2,
    OP_N  = 4'd3,
    OP_S  = 4'd4,
    OP_H  = 4'd5,
    OP_P  = 4'd6,
    OP_EQ = 4'd7,
    OP_X  = 4'd8
  } op_code_t;

  localparam logic [CFG_IDX_W-1:0] CFG_BREAK_ON_DELETION = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BREAK_ON_SKIP     = 1'd1;

  typedef struct packed {
    logic break_on_deletion;
    logic break_on_skip;
  } cfg_t;

  typedef struct packed {
    logic [POS_W-1:0]  read_start;
    logic [CODE_W-1:0] op_code;
    logic [LEN_W-1:0]  op_length;
    logic              first_op;
    logic              last_op;
  } op_t;

  typedef struct packed {
    logic [POS_W-1:0] block_start;
    logic [POS_W-1:0] block_end;
    logic             block_valid;
    logic             end_of_record;
    logic             bad_op;
  } blk_t;

  // what one request yields: a result or none
  typedef struct packed {
    logic emit;
    blk_t blk;
  } step_t;

  function automatic logic [POS_W-1:0] sat_add(input logic [POS_W-1:0] a,
                                               input logic [POS_W-1:0] b);
    logic [POS_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[POS_W] ? POS_MAX : s[POS_W-1:0];
  endfunction

endpackage

// ===== design/cbs_op_if.sv =====
// ----------------------------------------------------------------------------
// cbs_op_if: request channel of the CIGAR block splitter
// One CIGAR operation per request, valid/ready handshake.
// ----------------------------------------------------------------------------
interface cbs_op_if;
  logic                             valid;
  logic                             ready;
  logic [cbs_pkg::POS_W-1:0]        read_start;
  logic [cbs_pkg::CODE_W-1:0]       op_code;
  logic [cbs_pkg::LEN_W-1:0]        op_length;
  logic                             first_op;
  logic                             last_op;

  modport source (output valid, read_start, op_code, op_length, first_op, last_op,
                  input ready);
  modport sink (input valid, read_start, op_code, op_length, first_op, last_op,
                output ready);
endinterface

// ===== design/cbs_blk_if.sv =====
// ----------------------------------------------------------------------------
// cbs_blk_if: result channel of the CIGAR block splitter
// One aligned block or record status per result, valid/ready handshake.
// ----------------------------------------------------------------------------
interface cbs_blk_if;
  logic                      valid;
  logic                      ready;
  logic [cbs_pkg::POS_W-1:0] block_start;
  logic [cbs_pkg::POS_W-1:0] block_end;
  logic                      block_valid;
  logic                      end_of_record;
  logic                      bad_op;

  modport source (output valid, block_start, block_end, block_valid, end_of_record,
                  bad_op, input ready);
  modport sink (input valid, block_start, block_end, block_valid, end_of_record,
                bad_op, output ready);
endinterface

// ===== design/cbs_core.sv =====
// ----------------------------------------------------------------------------
// cbs_core: per-read state and single-pass step logic
// Holds position, open block length and failure flag; decides each result.
// ----------------------------------------------------------------------------
module cbs_core (
  input  logic           clk,
  input  logic           rst,
  input  cbs_pkg::cfg_t  cfg,
  input  cbs_pkg::op_t   op,
  input  logic           advance,
  output cbs_pkg::step_t step
);

  logic [cbs_pkg::POS_W-1:0] current_position;
  logic [cbs_pkg::POS_W-1:0] open_length;
  logic                      record_failed;

  logic [cbs_pkg::POS_W-1:0] current_position_next;
  logic [cbs_pkg::POS_W-1:0] open_length_next;
  logic                      record_failed_next;

  logic [cbs_pkg::POS_W-1:0] pos;
  logic [cbs_pkg::POS_W-1:0] olen;
  logic                      failed;
  logic [cbs_pkg::POS_W-1:0] ext_len;
  logic [cbs_pkg::POS_W-1:0] end_open;
  logic [cbs_pkg::POS_W-1:0] end_ext;
  logic                      brk;
  logic                      extend;

  // first operation reloads the record
  assign pos    = op.first_op ? op.read_start : current_position;
  assign olen   = op.first_op ? '0 : open_length;
  assign failed = op.first_op ? 1'b0 : record_failed;

  assign ext_len  = cbs_pkg::sat_add(olen, {{(cbs_pkg::POS_W-cbs_pkg::LEN_W){1'b0}},
                                            op.op_length});
  assign end_open = cbs_pkg::sat_add(pos, olen);
  assign end_ext  = cbs_pkg::sat_add(pos, ext_len);

  always_comb begin
    current_position_next = pos;
    open_length_next      = olen;
    record_failed_next    = failed;
    step                  = '0;
    brk                   = 1'b0;
    extend                = 1'b0;

    if (failed) begin
      if (op.last_op) begin
        step.emit              = 1'b1;
        step.blk.end_of_record = 1'b1;
        step.blk.bad_op        = 1'b1;
      end
    end else begin
      case (op.op_code) inside
        cbs_pkg::OP_M, cbs_pkg::OP_EQ, cbs_pkg::OP_X: begin
          open_length_next = ext_len;
          extend           = 1'b1;
        end
        cbs_pkg::OP_I, cbs_pkg::OP_S, cbs_pkg::OP_H, cbs_pkg::OP_P: begin
        end
        cbs_pkg::OP_D, cbs_pkg::OP_N: begin
          brk = (op.op_code == cbs_pkg::OP_D) ? cfg.break_on_deletion
                                              : cfg.break_on_skip;
          if (!brk) begin
            open_length_next = ext_len;
            extend           = 1'b1;
          end
        end
        default: begin
          record_failed_next     = 1'b1;
          open_length_next       = '0;
          step.emit              = 1'b1;
          step.blk.end_of_record = op.last_op;
          step.blk.bad_op        = 1'b1;
        end
      endcase

      if (brk) begin
        // close the open block and skip past it and the gap
        step.emit              = 1'b1;
        step.blk.block_start   = pos;
        step.blk.block_end     = end_open;
        step.blk.block_valid   = 1'b1;
        step.blk.end_of_record = op.last_op;
        current_position_next  = end_ext;
        open_length_next       = '0;
      end

      if (op.last_op && !step.emit) begin
        step.emit              = 1'b1;
        step.blk.end_of_record = 1'b1;
        if (open_length_next != '0) begin
          step.blk.block_start = pos;
          step.blk.block_end   = extend ? end_ext : end_open;
          step.blk.block_valid = 1'b1;
        end
      end
    end

    if (op.last_op) begin
      open_length_next   = '0;
      record_failed_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_position <= '0;
      open_length      <= '0;
      record_failed    <= 1'b0;
    end else if (advance) begin
      current_position <= current_position_next;
      open_length      <= open_length_next;
      record_failed    <= record_failed_next;
    end
  end

endmodule

// ===== design/cigar_block_splitter.sv =====
// ----------------------------------------------------------------------------
// cigar_block_splitter: cuts aligned reads into reference blocks
// Input register, single-pass step logic and result register.
// ----------------------------------------------------------------------------
// Usage:
//   op   : one CIGAR operation per request; first_op loads read_start, last_op
//          closes the record.
//   blk  : zero or one result per request, in request order: an aligned block,
//          a record close, or a bad-code report.
//   cfg  : cfg_we/cfg_index/cfg_data write break_on_deletion (index 0) and
//          break_on_skip (index 1); write only while the block is idle.
// Path: an accepted request waits in the input register; once the result
//   register is free the step runs and its result is registered there.
// Throughput: one request per cycle while blk.ready is high; the step is one
//   saturating add chain on the held position and block length.
// Stall: a held result keeps one further request waiting in the input
//   register; op.ready drops only when both registers are full.
// Reset: rst clears position, block length, failure flag and both valid
//   flags, and sets the break controls to their defaults (skip breaks).
// ----------------------------------------------------------------------------
module cigar_block_splitter (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [cbs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cbs_pkg::CFG_DATA_W-1:0] cfg_data,
  cbs_op_if.sink                         op,
  cbs_blk_if.source                      blk
);

  cbs_pkg::cfg_t  cfg;
  cbs_pkg::op_t   op_q;
  logic           op_valid;
  cbs_pkg::blk_t  res;
  logic           res_valid;
  cbs_pkg::step_t step;
  logic           out_free;
  logic           advance;

  assign out_free = !res_valid || blk.ready;
  assign advance  = op_valid && out_free;
  assign op.ready = !op_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.break_on_deletion <= 1'b0;
      cfg.break_on_skip     <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        cbs_pkg::CFG_BREAK_ON_DELETION: cfg.break_on_deletion <= cfg_data[0];
        cbs_pkg::CFG_BREAK_ON_SKIP:     cfg.break_on_skip     <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // hold the request until the step can run
  always_ff @(posedge clk) begin
    if (rst) begin
      op_valid <= 1'b0;
    end else if (op.ready) begin
      op_valid <= op.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (op.valid && op.ready) begin
      op_q.read_start <= op.read_start;
      op_q.op_code    <= op.op_code;
      op_q.op_length  <= op.op_length;
      op_q.first_op   <= op.first_op;
      op_q.last_op    <= op.last_op;
    end
  end

  cbs_core u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .op      (op_q),
    .advance (advance),
    .step    (step)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance && step.emit) begin
      res_valid <= 1'b1;
    end else if (blk.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step.emit) begin
      res <= step.blk;
    end
  end

  assign blk.valid         = res_valid;
  assign blk.block_start   = res.block_start;
  assign blk.block_end     = res.block_end;
  assign blk.block_valid   = res.block_valid;
  assign blk.end_of_record = res.end_of_record;
  assign blk.bad_op        = res.bad_op;

endmodule
